// ----- src/xses_pkg.sv -----
package xses_pkg;

    localparam int MAX_NAME_BYTES = 255;
    localparam logic [7:0] NAME_CAP = 8'((MAX_NAME_BYTES < 255) ? MAX_NAME_BYTES : 255);

    localparam logic [2:0] DECL_LEN = 3'd6;
    localparam logic [2:0] DECL_RESUME = 3'd2;

    localparam logic [7:0] CONT_FLIP = 8'h80;
    localparam logic [7:0] CONT_LIMIT = 8'h40;
    localparam logic [20:0] CODE_VALUE_MASK = 21'h1fffff;

    typedef enum logic [1:0] {
        EV_NAME_BYTE = 2'd0,
        EV_START     = 2'd1,
        EV_END_DATA  = 2'd2,
        EV_ERROR     = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        PH_FIRST     = 4'd0,
        PH_LT        = 4'd1,
        PH_DECL      = 4'd2,
        PH_DECL_BODY = 4'd3,
        PH_DECL_Q    = 4'd4,
        PH_WS        = 4'd5,
        PH_NAME      = 4'd6,
        PH_UTF8      = 4'd7,
        PH_ATTR      = 4'd8,
        PH_DONE      = 4'd9
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  decl_idx;
        logic [1:0]  utf_rem;
        logic [1:0]  utf_len;
        logic [20:0] utf_val;
        logic [7:0]  name_cnt;
    } t_state;

    typedef struct packed {
        logic       valid;
        t_event     ev;
        logic [6:0] name_byte;
        logic [7:0] name_length;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase: PH_FIRST, decl_idx: 3'd0, utf_rem: 2'd0, utf_len: 2'd0,
        utf_val: 21'd0, name_cnt: 8'd0
    };

    function automatic logic [7:0] decl_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h3c;
            3'd1:    c = 8'h3f;
            3'd2:    c = 8'h78;
            3'd3:    c = 8'h6d;
            3'd4:    c = 8'h6c;
            3'd5:    c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] lead_mask(input logic [1:0] len);
        logic [7:0] m;
        case (len)
            2'd0:    m = 8'h7f;
            2'd1:    m = 8'h1f;
            2'd2:    m = 8'h0f;
            default: m = 8'h07;
        endcase
        return m;
    endfunction

    function automatic logic [20:0] min_value(input logic [1:0] len);
        logic [20:0] v;
        case (len)
            2'd0:    v = 21'h0;
            2'd1:    v = 21'h80;
            2'd2:    v = 21'h800;
            default: v = 21'h10000;
        endcase
        return v;
    endfunction

endpackage

// ----- src/xses_step.sv -----
module xses_step (
    input  xses_pkg::t_state  i_state,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output xses_pkg::t_state  o_next,
    output xses_pkg::t_result o_result
);

    // One byte of the scanner: next state and the optional result.
    always_comb begin
        logic [7:0]  b;
        logic        last;
        logic        is_name;
        logic        is_space;
        logic [1:0]  follow;
        logic [7:0]  c;
        logic [20:0] val;
        logic [1:0]  rem;
        logic        fail;
        logic        attr;
        logic        name_path;
        logic [7:0]  cnt;

        b = i_data_byte;
        last = i_last_byte;
        is_name = (b inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
                             8'h5f, 8'h2d, 8'h2e, 8'h3a});
        is_space = (b inside {8'h20, 8'h09, 8'h0d, 8'h0a});
        if (b inside {[8'hc2:8'hdf]}) begin
            follow = 2'd1;
        end else if (b inside {[8'he0:8'hef]}) begin
            follow = 2'd2;
        end else if (b inside {[8'hf0:8'hf4]}) begin
            follow = 2'd3;
        end else begin
            follow = 2'd0;
        end
        c = b ^ xses_pkg::CONT_FLIP;
        val = ((i_state.utf_val << 6) | {13'd0, c}) & xses_pkg::CODE_VALUE_MASK;
        rem = i_state.utf_rem - 2'd1;

        o_next = i_state;
        o_result = '0;
        fail = 1'b0;
        attr = 1'b0;
        name_path = 1'b0;
        cnt = i_state.name_cnt;

        case (i_state.phase)
            xses_pkg::PH_FIRST: begin
                if (b == 8'h3c) begin
                    if (last) begin
                        fail = 1'b1;
                    end else begin
                        o_next.phase = xses_pkg::PH_LT;
                    end
                end else if (is_space) begin
                    o_next.phase = xses_pkg::PH_WS;
                    if (last) begin
                        o_next.phase = xses_pkg::PH_DONE;
                        o_result.valid = 1'b1;
                        o_result.ev = xses_pkg::EV_END_DATA;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            xses_pkg::PH_LT: begin
                if (b == 8'h3f) begin
                    if (last) begin
                        fail = 1'b1;
                    end else begin
                        o_next.decl_idx = xses_pkg::DECL_RESUME;
                        o_next.phase = xses_pkg::PH_DECL;
                    end
                end else begin
                    cnt = 8'd0;
                    o_next.name_cnt = 8'd0;
                    name_path = 1'b1;
                end
            end
            xses_pkg::PH_DECL: begin
                if (i_state.decl_idx >= xses_pkg::DECL_LEN
                        || b != xses_pkg::decl_char(i_state.decl_idx) || last) begin
                    fail = 1'b1;
                end else begin
                    o_next.decl_idx = i_state.decl_idx + 3'd1;
                    if (i_state.decl_idx + 3'd1 == xses_pkg::DECL_LEN) begin
                        o_next.phase = xses_pkg::PH_DECL_BODY;
                    end
                end
            end
            xses_pkg::PH_DECL_BODY: begin
                if (last) begin
                    fail = 1'b1;
                end else if (b == 8'h3f) begin
                    o_next.phase = xses_pkg::PH_DECL_Q;
                end
            end
            xses_pkg::PH_DECL_Q: begin
                if (b != 8'h3e) begin
                    fail = 1'b1;
                end else if (last) begin
                    o_next.phase = xses_pkg::PH_DONE;
                    o_result.valid = 1'b1;
                    o_result.ev = xses_pkg::EV_END_DATA;
                end else begin
                    o_next.phase = xses_pkg::PH_WS;
                end
            end
            xses_pkg::PH_WS: begin
                if (is_space) begin
                    o_next.phase = xses_pkg::PH_WS;
                    if (last) begin
                        o_next.phase = xses_pkg::PH_DONE;
                        o_result.valid = 1'b1;
                        o_result.ev = xses_pkg::EV_END_DATA;
                    end
                end else if (b == 8'h3c) begin
                    if (last) begin
                        fail = 1'b1;
                    end else begin
                        o_next.name_cnt = 8'd0;
                        o_next.phase = xses_pkg::PH_NAME;
                    end
                end else begin
                    fail = 1'b1;
                end
            end
            xses_pkg::PH_NAME: begin
                name_path = 1'b1;
            end
            xses_pkg::PH_UTF8: begin
                if (c >= xses_pkg::CONT_LIMIT) begin
                    fail = 1'b1;
                end else begin
                    o_next.utf_val = val;
                    o_next.utf_rem = rem;
                    if (rem == 2'd0) begin
                        if (val < xses_pkg::min_value(i_state.utf_len) || last) begin
                            fail = 1'b1;
                        end else begin
                            o_next.phase = xses_pkg::PH_ATTR;
                        end
                    end else if (last) begin
                        fail = 1'b1;
                    end
                end
            end
            xses_pkg::PH_ATTR: begin
                attr = 1'b1;
            end
            default: begin
            end
        endcase

        // Name character or terminator lead byte.
        if (name_path) begin
            if (!b[7]) begin
                if (b == 8'h00) begin
                    fail = 1'b1;
                end else if (is_name) begin
                    if (last) begin
                        fail = 1'b1;
                    end else begin
                        if (cnt < xses_pkg::NAME_CAP) begin
                            o_next.name_cnt = cnt + 8'd1;
                        end
                        o_next.phase = xses_pkg::PH_NAME;
                        o_result.valid = 1'b1;
                        o_result.ev = xses_pkg::EV_NAME_BYTE;
                        o_result.name_byte = b[6:0];
                    end
                end else if (cnt == 8'd0) begin
                    fail = 1'b1;
                end else begin
                    attr = 1'b1;
                end
            end else if (follow == 2'd0 || cnt == 8'd0 || last) begin
                fail = 1'b1;
            end else begin
                o_next.utf_rem = follow;
                o_next.utf_len = follow;
                o_next.utf_val = {13'd0, b & xses_pkg::lead_mask(follow)};
                o_next.phase = xses_pkg::PH_UTF8;
            end
        end

        // Attribute area: wait for the closing bracket.
        if (attr) begin
            if (b == 8'h3e) begin
                o_next.phase = xses_pkg::PH_DONE;
                o_result.valid = 1'b1;
                o_result.ev = xses_pkg::EV_START;
                o_result.name_length = o_next.name_cnt;
            end else if (last) begin
                fail = 1'b1;
            end else begin
                o_next.phase = xses_pkg::PH_ATTR;
            end
        end

        if (fail) begin
            o_next.phase = xses_pkg::PH_DONE;
            o_result = '0;
            o_result.valid = 1'b1;
            o_result.ev = xses_pkg::EV_ERROR;
        end

        // The last byte of a message always rearms the scanner.
        if (last) begin
            o_next = xses_pkg::STATE_RESET;
        end
    end

endmodule

// ----- src/xml_start_element_scanner.sv -----
// XML start element scanner.
// The input channel (i_valid / o_ready) carries one message byte per
// transaction, i_data_byte with i_last_byte set on the final byte of the
// message. The output channel (o_valid / i_ready) carries at most one event
// per input byte: a name byte, start element found with the name length,
// end of data without an element, or a format error.
// Each accepted byte is scanned in the cycle it is accepted; its event, if
// any, is shown on the output register from the next cycle on, and one byte
// is taken per cycle while the receiver does not stall. The per-byte scanner
// step is the only logic between the scan state registers and the result
// register.
// When the receiver stalls, the held event stays on the outputs and o_ready
// is low for as long as an event waits and i_ready is low, whether or not
// the next byte would produce an event.
// A synchronous active-low reset clears the scan state to "expect first
// byte" and empties the output register. The last byte of every message
// also rearms the scanner, whatever state it was in.
module xml_start_element_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_event_res,
    output logic [6:0] o_name_byte,
    output logic [7:0] o_name_length
);

    xses_pkg::t_state  r_state;
    xses_pkg::t_state  n_state;
    xses_pkg::t_result w_result;
    logic              r_out_valid;
    xses_pkg::t_event  r_event;
    logic [6:0]        r_name_byte;
    logic [7:0]        r_name_length;
    logic              w_in_accept;

    // A new byte may enter whenever the output register is free or is being
    // drained in this same cycle.
    assign o_ready = !r_out_valid || i_ready;
    assign w_in_accept = i_valid && o_ready;

    xses_step u_step (
        .i_state     (r_state),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_next      (n_state),
        .o_result    (w_result)
    );

    // Scan state advances only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xses_pkg::STATE_RESET;
        end else if (w_in_accept) begin
            r_state <= n_state;
        end
    end

    // Output register: loaded when the accepted byte produces an event,
    // cleared when the held event is taken and nothing replaces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept && w_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_result.valid) begin
            r_event       <= w_result.ev;
            r_name_byte   <= w_result.name_byte;
            r_name_length <= w_result.name_length;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_res   = r_event;
    assign o_name_byte   = r_name_byte;
    assign o_name_length = r_name_length;

`ifndef SYNTHESIS
    // The last byte of a message always leaves the scanner rearmed.
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_last_byte) |=> (r_state.phase == xses_pkg::PH_FIRST
            && r_state.name_cnt == 8'd0))
        else $error("scanner not rearmed after last byte");

    // The name count never passes its saturation limit.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.name_cnt <= xses_pkg::NAME_CAP)
        else $error("name count above its limit");

    // A start element is reported only after at least one name byte.
    a_start_has_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event == xses_pkg::EV_START) |-> (r_name_length != 8'd0))
        else $error("start element with empty name");
`endif

endmodule

// ----- tb/xml_start_element_scanner_tb.sv -----
module xml_start_element_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Half clock period, reset length and the output latency of the scanner.
    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int LATENCY_CYCLES = 1;

    // The receiver is held off once for this many cycles in the first phase
    // while the sender keeps offering bytes. With only one output register
    // the scanner must then stall its input.
    localparam int LONG_HOLD = 300;

    // Random bytes per idle phase, the length of the one name that runs the
    // name counter into saturation, and the bounded wait for late events.
    localparam int PHASE_BYTES     = 310;
    localparam int LONG_NAME_LEN   = 258;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int MAX_MISMATCH_PRINTS = 40;

    // Characters that matter to the scanner.
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_EQUAL = 8'h3d;
    localparam logic [47:0] DECL_TEXT = "<?xml ";

    // One input transaction: a message byte and its end-of-message flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_msg_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_event_res;
    logic [6:0] o_name_byte;
    logic [7:0] o_name_length;

    xml_start_element_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_event_res   (o_event_res),
        .o_name_byte   (o_name_byte),
        .o_name_length (o_name_length)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Bytes waiting to be driven, and the events the scanner owes us, oldest
    // first. The message under construction lives in msg_buf.
    t_msg_byte         pending_bytes[$];
    xses_pkg::t_result expected_events[$];
    logic [7:0]        msg_buf[$];

    // Idle percentages for the current phase and the long hold handshake.
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_request = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;

    // Bookkeeping for the verdict and the summary.
    int mismatch_count = 0;
    int events_checked = 0;
    int event_tally [4];
    int bytes_queued = 0;
    int bytes_target = 0;
    int messages_queued = 0;
    int input_stall_cycles = 0;

    string name_set =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_-.:";

    // Our own copy of the scan state.
    xses_pkg::t_phase sc_phase;
    logic [2:0]       sc_decl_idx;
    logic [1:0]       sc_utf_left;
    logic [1:0]       sc_utf_len;
    logic [20:0]      sc_utf_acc;
    logic [7:0]       sc_name_cnt;

    //------------------------------------------------------------------------
    // Scanner prediction
    //------------------------------------------------------------------------

    // Return to the "expect first byte" state, as reset and every final
    // message byte do.
    function automatic void rearm_scanner();
        sc_phase    = xses_pkg::PH_FIRST;
        sc_decl_idx = 3'd0;
        sc_utf_left = 2'd0;
        sc_utf_len  = 2'd0;
        sc_utf_acc  = 21'd0;
        sc_name_cnt = 8'd0;
    endfunction

    function automatic xses_pkg::t_result make_event(input xses_pkg::t_event ev,
                                                     input logic [6:0] nb,
                                                     input logic [7:0] nl);
        xses_pkg::t_result r;
        r = '{valid: 1'b1, ev: ev, name_byte: nb, name_length: nl};
        return r;
    endfunction

    // A format error ends the scan of this message.
    function automatic xses_pkg::t_result flag_error();
        sc_phase = xses_pkg::PH_DONE;
        return make_event(xses_pkg::EV_ERROR, 7'd0, 8'd0);
    endfunction

    // Inside the attributes only '>' matters; running out of data is an error.
    function automatic xses_pkg::t_result attr_step(input logic [7:0] b, input logic last);
        xses_pkg::t_result r;
        r = '0;
        if (b == CH_GT) begin
            sc_phase = xses_pkg::PH_DONE;
            r = make_event(xses_pkg::EV_START, 7'd0, sc_name_cnt);
        end else if (last) begin
            r = flag_error();
        end else begin
            sc_phase = xses_pkg::PH_ATTR;
        end
        return r;
    endfunction

    // Whitespace before the element; '<' opens the name.
    function automatic xses_pkg::t_result space_step(input logic [7:0] b, input logic last);
        xses_pkg::t_result r;
        r = '0;
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
            sc_phase = xses_pkg::PH_WS;
            if (last) begin
                sc_phase = xses_pkg::PH_DONE;
                r = make_event(xses_pkg::EV_END_DATA, 7'd0, 8'd0);
            end
        end else if (b == CH_LT) begin
            if (last) begin
                r = flag_error();
            end else begin
                sc_name_cnt = 8'd0;
                sc_phase = xses_pkg::PH_NAME;
            end
        end else begin
            r = flag_error();
        end
        return r;
    endfunction

    // One byte at a name position: a name character, the ASCII terminator,
    // or the lead byte of a UTF-8 terminator.
    function automatic xses_pkg::t_result name_step(input logic [7:0] b, input logic last);
        xses_pkg::t_result r;
        logic              name_ch;
        logic [1:0]        seq_len;
        logic [7:0]        payload;
        r = '0;
        name_ch = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
                  (b >= "0" && b <= "9") || b == "_" || b == "-" || b == "." || b == ":";
        if (!b[7]) begin
            if (b == 8'h00) begin
                r = flag_error();
            end else if (name_ch) begin
                // A name byte that is also the final byte gives only the error.
                if (last) begin
                    r = flag_error();
                end else begin
                    if (sc_name_cnt < xses_pkg::NAME_CAP) sc_name_cnt = sc_name_cnt + 8'd1;
                    sc_phase = xses_pkg::PH_NAME;
                    r = make_event(xses_pkg::EV_NAME_BYTE, b[6:0], 8'd0);
                end
            end else if (sc_name_cnt == 8'd0) begin
                r = flag_error();
            end else begin
                r = attr_step(b, last);
            end
        end else begin
            if (b >= 8'hc2 && b <= 8'hdf) seq_len = 2'd1;
            else if (b >= 8'he0 && b <= 8'hef) seq_len = 2'd2;
            else if (b >= 8'hf0 && b <= 8'hf4) seq_len = 2'd3;
            else seq_len = 2'd0;
            case (seq_len)
                2'd1:    payload = b & 8'h1f;
                2'd2:    payload = b & 8'h0f;
                default: payload = b & 8'h07;
            endcase
            // Even a well-formed multibyte character cannot start a name.
            if (seq_len == 2'd0 || sc_name_cnt == 8'd0 || last) begin
                r = flag_error();
            end else begin
                sc_utf_left = seq_len;
                sc_utf_len  = seq_len;
                sc_utf_acc  = {13'd0, payload};
                sc_phase    = xses_pkg::PH_UTF8;
            end
        end
        return r;
    endfunction

    // Continuation bytes of the UTF-8 terminator, with the overlong check on
    // the final one. Values past the Unicode range and surrogates pass.
    function automatic xses_pkg::t_result utf8_step(input logic [7:0] b, input logic last);
        xses_pkg::t_result r;
        logic [7:0]        c;
        logic [20:0]       floor_val;
        r = '0;
        c = b ^ 8'h80;
        case (sc_utf_len)
            2'd1:    floor_val = 21'h80;
            2'd2:    floor_val = 21'h800;
            2'd3:    floor_val = 21'h10000;
            default: floor_val = 21'h0;
        endcase
        if (c >= 8'h40) begin
            r = flag_error();
        end else begin
            sc_utf_acc  = {sc_utf_acc[14:0], c[5:0]};
            sc_utf_left = sc_utf_left - 2'd1;
            if (sc_utf_left == 2'd0) begin
                if (sc_utf_acc < floor_val) r = flag_error();
                else if (last) r = flag_error();
                else sc_phase = xses_pkg::PH_ATTR;
            end else if (last) begin
                r = flag_error();
            end
        end
        return r;
    endfunction

    // Advance the scan state by one accepted byte; returns the event it
    // causes, if any (valid low otherwise).
    function automatic xses_pkg::t_result scan_byte(input logic [7:0] b, input logic last);
        xses_pkg::t_result r;
        r = '0;
        case (sc_phase)
            xses_pkg::PH_FIRST: begin
                if (b == CH_LT) begin
                    if (last) r = flag_error();
                    else sc_phase = xses_pkg::PH_LT;
                end else begin
                    r = space_step(b, last);
                end
            end
            xses_pkg::PH_LT: begin
                if (b == CH_QMARK) begin
                    if (last) begin
                        r = flag_error();
                    end else begin
                        sc_decl_idx = 3'd2;
                        sc_phase = xses_pkg::PH_DECL;
                    end
                end else begin
                    sc_name_cnt = 8'd0;
                    r = name_step(b, last);
                end
            end
            xses_pkg::PH_DECL: begin
                if (sc_decl_idx >= 3'd6 || last
                        || b != DECL_TEXT[8 * (5 - sc_decl_idx) +: 8]) begin
                    r = flag_error();
                end else begin
                    sc_decl_idx = sc_decl_idx + 3'd1;
                    if (sc_decl_idx == 3'd6) sc_phase = xses_pkg::PH_DECL_BODY;
                end
            end
            xses_pkg::PH_DECL_BODY: begin
                if (last) r = flag_error();
                else if (b == CH_QMARK) sc_phase = xses_pkg::PH_DECL_Q;
            end
            xses_pkg::PH_DECL_Q: begin
                if (b != CH_GT) begin
                    r = flag_error();
                end else if (last) begin
                    sc_phase = xses_pkg::PH_DONE;
                    r = make_event(xses_pkg::EV_END_DATA, 7'd0, 8'd0);
                end else begin
                    sc_phase = xses_pkg::PH_WS;
                end
            end
            xses_pkg::PH_WS:   r = space_step(b, last);
            xses_pkg::PH_NAME: r = name_step(b, last);
            xses_pkg::PH_UTF8: r = utf8_step(b, last);
            xses_pkg::PH_ATTR: r = attr_step(b, last);
            default: r = '0;
        endcase
        if (last) rearm_scanner();
        return r;
    endfunction

    //------------------------------------------------------------------------
    // Stimulus construction
    //------------------------------------------------------------------------

    function automatic logic [7:0] random_space();
        logic [7:0] c;
        case ($urandom_range(3))
            0:       c = CH_SPACE;
            1:       c = CH_TAB;
            2:       c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

    // "<?xml " followed by a short body free of '?', then "?>".
    task automatic add_declaration();
        logic [7:0] c;
        for (int k = 5; k >= 0; k--) msg_buf.push_back(DECL_TEXT[8 * k +: 8]);
        repeat ($urandom_range(0, 4)) begin
            c = 8'($urandom_range(255));
            if (c == CH_QMARK) c = CH_SPACE;
            msg_buf.push_back(c);
        end
        msg_buf.push_back(CH_QMARK);
        msg_buf.push_back(CH_GT);
    endtask

    // Move the message under construction to the driver, flagging its final
    // byte.
    task automatic flush_message();
        for (int k = 0; k < msg_buf.size(); k++)
            pending_bytes.push_back('{data: msg_buf[k], last: (k == msg_buf.size() - 1)});
        bytes_queued += msg_buf.size();
        messages_queued++;
        msg_buf.delete();
    endtask

    // A short directed message given MSB first in the low n bytes.
    task automatic queue_packed(input logic [63:0] text, input int n);
        for (int k = n - 1; k >= 0; k--) msg_buf.push_back(text[8 * k +: 8]);
        flush_message();
    endtask

    // A UTF-8 coded terminator: mostly well formed, sometimes overlong, now
    // and then with a damaged continuation byte. Four-byte values run past
    // the range that lead bytes 0xF0 to 0xF4 can carry.
    task automatic add_utf8_terminator();
        int          seq_len;
        int          bad_pos;
        logic        overlong;
        logic [20:0] cp;
        logic [7:0]  c;
        seq_len  = $urandom_range(1, 3);
        overlong = ($urandom_range(4) == 0);
        bad_pos  = ($urandom_range(7) == 0) ? $urandom_range(seq_len - 1) : -1;
        case (seq_len)
            1: cp = overlong ? 21'($urandom_range(32'h7f))
                             : 21'($urandom_range(32'h7ff, 32'h80));
            2: cp = overlong ? 21'($urandom_range(32'h7ff))
                             : 21'($urandom_range(32'hffff, 32'h800));
            default: cp = overlong ? 21'($urandom_range(32'hffff))
                                   : 21'($urandom_range(32'h1fffff, 32'h10000));
        endcase
        case (seq_len)
            1:       msg_buf.push_back(8'hc0 | {3'd0, cp[10:6]});
            2:       msg_buf.push_back(8'he0 | {4'd0, cp[15:12]});
            default: msg_buf.push_back(8'hf0 | {5'd0, cp[20:18]});
        endcase
        for (int k = seq_len - 1; k >= 0; k--) begin
            c = 8'h80 | {2'b00, cp[6 * k +: 6]};
            if (k == bad_pos) begin
                c = 8'($urandom_range(255));
                if (c[7:6] == 2'b10) c[6] = 1'b1;
            end
            msg_buf.push_back(c);
        end
    endtask

    // One random message. Most are well formed with random content; the rest
    // are noise, whitespace-only text, or well-formed text that is corrupted
    // or cut short. A nonzero forced_name_len builds an intact message with a
    // name of that length.
    task automatic queue_message(input int forced_name_len);
        int         pick;
        int         cut;
        logic [7:0] c;
        pick = (forced_name_len != 0) ? 99 : $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6))
                msg_buf.push_back(($urandom_range(3) == 0) ? CH_LT : 8'($urandom_range(255)));
        end else if (pick < 14) begin
            if ($urandom_range(1) == 0) add_declaration();
            repeat ($urandom_range(1, 3)) msg_buf.push_back(random_space());
        end else begin
            if ($urandom_range(2) == 0) add_declaration();
            repeat ($urandom_range(0, 2)) msg_buf.push_back(random_space());
            msg_buf.push_back(CH_LT);
            repeat ((forced_name_len != 0) ? forced_name_len : $urandom_range(1, 6))
                msg_buf.push_back(8'(name_set[$urandom_range(name_set.len() - 1)]));
            case ($urandom_range(9))
                0, 1, 2, 3: add_utf8_terminator();
                4:          msg_buf.push_back(8'($urandom_range(8'hff, 8'h80)));
                5:          msg_buf.push_back(CH_GT);
                6:          msg_buf.push_back(CH_SLASH);
                7:          msg_buf.push_back(CH_EQUAL);
                default:    msg_buf.push_back(random_space());
            endcase
            repeat ($urandom_range(0, 4)) begin
                c = 8'($urandom_range(255));
                if (c == CH_GT) c = CH_SPACE;
                msg_buf.push_back(c);
            end
            msg_buf.push_back(CH_GT);
            // Bytes after the final event are ignored until the last one.
            repeat ($urandom_range(0, 2)) msg_buf.push_back(8'($urandom_range(255)));
        end
        if (forced_name_len == 0 && pick >= 8) begin
            if ($urandom_range(9) == 0)
                msg_buf[$urandom_range(msg_buf.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(7) == 0) begin
                cut = $urandom_range(1, msg_buf.size());
                while (msg_buf.size() > cut) void'(msg_buf.pop_back());
            end
        end
        flush_message();
    endtask

    //------------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_MISMATCH_PRINTS)
            $display("MISMATCH at %0t: %s, got 'h%0h, expected 'h%0h",
                     $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Wait until every queued byte has been accepted and every owed event has
    // come out, then let the pipeline settle. An event that never arrives is
    // reported after a bounded wait rather than left to the global timeout.
    task automatic drain();
        int waited;
        waited = 0;
        while (pending_bytes.size() != 0 || i_valid) @(negedge i_clk);
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        while (expected_events.size() != 0) begin
            report_mismatch("expected event never arrived", 32'd0,
                            32'(expected_events[0].ev));
            void'(expected_events.pop_front());
        end
        repeat (LATENCY_CYCLES + 3) @(negedge i_clk);
    endtask

    //------------------------------------------------------------------------
    // Input driver: offers the next pending byte when the channel is free, unless it idles at the phase rate.
    // A byte accepted at this edge is run through the predictor first, so the
    // expected event is queued before the scanner can present it.
    //------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        t_msg_byte         item;
        xses_pkg::t_result predicted;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predicted = scan_byte(i_data_byte, i_last_byte);
                if (predicted.valid) expected_events.push_back(predicted);
            end
            if (i_valid && !o_ready) input_stall_cycles++;
            // Valid is only dropped or replaced once the current transaction
            // has completed, so the payload holds steady while stalled.
            if (!i_valid || o_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = pending_bytes.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= item.data;
                    i_last_byte <= item.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------------
    // Receiver ready: random stalls at the phase rate, plus one long hold
    // counted out here when the stimulus process asks for it.
    //------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD - 1;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    //------------------------------------------------------------------------
    // Output monitor: every event transaction is matched, field by field,
    // against the oldest expectation.
    //------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_events
        xses_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("event with nothing expected", 32'(o_event_res), 32'd0);
            end else begin
                want = expected_events.pop_front();
                if (o_event_res != want.ev)
                    report_mismatch("event_res", 32'(o_event_res), 32'(want.ev));
                if (o_name_byte != want.name_byte)
                    report_mismatch("name_byte", 32'(o_name_byte), 32'(want.name_byte));
                if (o_name_length != want.name_length)
                    report_mismatch("name_length", 32'(o_name_length),
                                    32'(want.name_length));
                events_checked++;
                event_tally[want.ev]++;
            end
        end
    end

    //------------------------------------------------------------------------
    // Stimulus sequence: directed messages, then random messages in four
    // idle phases (none, sender idle, receiver stalls, both), each drained
    // before the next begins.
    //------------------------------------------------------------------------
    initial begin
        for (int k = 0; k < 4; k++) event_tally[k] = 0;
        rearm_scanner();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (phase == 0) begin
                // Whitespace only: end of data without an element.
                queue_packed(64'h200a, 2);
                // Message that ends inside the declaration.
                queue_packed(64'h3c3f78, 3);
                // Name, then a four-byte terminator past the Unicode range,
                // the start event, and an ignored 0xFF as the final byte.
                queue_packed(64'h3c61_f490_8080_3eff, 8);
                // A name byte that is also the final byte.
                queue_packed(64'h3c6162, 3);
                // A valid two-byte character where the name should begin.
                queue_packed(64'h3cc3a9, 3);
                // A zero byte ending the name.
                queue_packed(64'h3c6100, 3);
                // Hold the receiver off while the sender keeps going.
                hold_request = 1'b1;
            end
            bytes_target += PHASE_BYTES;
            if (phase == 1) queue_message(LONG_NAME_LEN);
            while (bytes_queued < bytes_target) queue_message(0);
            drain();
        end

        $display("Scanned %0d bytes in %0d messages; checked %0d events: %0d name bytes,",
                 bytes_queued, messages_queued, events_checked,
                 event_tally[xses_pkg::EV_NAME_BYTE]);
        $display("%0d starts, %0d end-of-data, %0d format errors; input stalled %0d cycles.",
                 event_tally[xses_pkg::EV_START], event_tally[xses_pkg::EV_END_DATA],
                 event_tally[xses_pkg::EV_ERROR], input_stall_cycles);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #2_000_000;
        $display("Timeout with %0d bytes pending and %0d events outstanding.",
                 pending_bytes.size(), expected_events.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
src/xses_pkg.sv
src/xses_step.sv
src/xml_start_element_scanner.sv
tb/xml_start_element_scanner_tb.sv
